/* rtl/wss_pkg.sv */
`timescale 1ns / 1ps
// Package for the wildcard substring search block: sizes, register indexes
// and the configuration struct shared by the register file and the matcher.
// No dependencies.
package wss_pkg;

  // Longest pattern the search supports, in bytes.
  localparam int MAX_PATTERN = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  // Byte value that matches any data byte at pattern positions after the first.
  localparam logic [7:0] WILDCARD_CHAR = 8'h3F;

  // Configuration port sizing: three 64-bit registers at 8-byte spacing.
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = LEN_W'(1);

  typedef logic [MAX_PATTERN-1:0][7:0] pattern_t;

  // Decoded search configuration handed to the matcher.
  typedef struct packed {
    pattern_t               pattern;
    logic [MAX_PATTERN-1:0] active;     // positions below the effective length
    logic [MAX_PATTERN-1:0] final_pos;  // one-hot: last position of the pattern
  } cfg_t;

endpackage

/* rtl/wss_if.sv */
`timescale 1ns / 1ps
// Stream channel interfaces for the wildcard substring search block:
// the byte input channel and the result channel. No dependencies.
interface wss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface wss_out_if;
  logic valid;
  logic ready;
  logic match_found;
  logic buffer_done;

  modport source (output valid, match_found, buffer_done, input ready);
  modport sink   (input valid, match_found, buffer_done, output ready);
endinterface

/* rtl/wss_cfg_regs.sv */
`timescale 1ns / 1ps
// APB-style configuration registers for the wildcard substring search and
// the decode of the pattern length into position masks. Uses wss_pkg.
module wss_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wss_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wss_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wss_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output wss_pkg::cfg_t                  cfg
);
  import wss_pkg::*;

  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;
  logic [LEN_W-1:0]     pattern_length;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [LEN_W-1:0]     len_eff;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= PATTERN_LENGTH_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_LOW:    pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high   <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    case (reg_idx)
      REG_PATTERN_LOW:    prdata = pattern_low;
      REG_PATTERN_HIGH:   prdata = pattern_high;
      REG_PATTERN_LENGTH: prdata = APB_DATA_W'(pattern_length);
      default:            prdata = '0;
    endcase
  end

  // A length of zero behaves as one; anything above the maximum is clamped.
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
  end

  // Turn the length into a mask of active positions and the final position.
  always_comb begin
    cfg.pattern = {pattern_high, pattern_low};
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cfg.active[i]    = LEN_W'(i) < len_eff;
      cfg.final_pos[i] = LEN_W'(i + 1) == len_eff;
    end
  end

endmodule

/* rtl/wss_matcher.sv */
`timescale 1ns / 1ps
// Prefix match state and per-byte match logic of the wildcard substring
// search: one bit per pattern position plus a sticky found flag. Uses wss_pkg.
module wss_matcher (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  wss_pkg::cfg_t cfg,
  output logic          match_found
);
  import wss_pkg::*;

  logic [MAX_PATTERN-1:0] prefix_hits;
  logic [MAX_PATTERN-1:0] prefix_hits_next;
  logic                   found_flag;
  logic                   found_flag_next;

  // Each position extends the prefix that ended one byte earlier. The first
  // position always compares literally; later ones also accept the wildcard.
  always_comb begin
    prefix_hits_next[0] = data_byte == cfg.pattern[0];
    for (int i = 1; i < MAX_PATTERN; i++) begin
      prefix_hits_next[i] = prefix_hits[i-1] && cfg.active[i] &&
                            ((cfg.pattern[i] == data_byte) ||
                             (cfg.pattern[i] == WILDCARD_CHAR));
    end
  end

  assign found_flag_next = found_flag || (|(prefix_hits_next & cfg.final_pos));
  assign match_found     = found_flag_next;

  // State advances once per byte and clears at the end of each buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_hits <= '0;
      found_flag  <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        prefix_hits <= '0;
        found_flag  <= 1'b0;
      end else begin
        prefix_hits <= prefix_hits_next;
        found_flag  <= found_flag_next;
      end
    end
  end

endmodule

/* rtl/wildcard_substring_search.sv */
`timescale 1ns / 1ps
// Wildcard substring search: reports whether a configured pattern occurs in
// a byte buffer. A byte goes through an input register, then the match logic
// into a result register. Throughput is one byte per cycle while the result
// channel is ready; the input register and the result register each hold an
// item, so one more byte is taken while a result waits to be taken.
// Synchronous reset empties both registers, clears the search state and sets
// the pattern registers to zero with a pattern length of one.
module wildcard_substring_search (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wss_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wss_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wss_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  wss_in_if.sink                         byte_ch,
  wss_out_if.source                      result_ch
);
  import wss_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       s1_advance;
  logic       match_next;
  logic       out_valid;
  logic       out_match;
  logic       out_done;

  wss_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wss_matcher u_matcher (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_advance),
    .data_byte   (s1_data),
    .last_byte   (s1_last),
    .cfg         (cfg),
    .match_found (match_next)
  );

  // The input register moves on whenever the result register is free or drains.
  assign s1_advance    = s1_valid && (!out_valid || result_ch.ready);
  assign byte_ch.ready = !s1_valid || s1_advance;

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      s1_data <= byte_ch.data_byte;
      s1_last <= byte_ch.last_byte;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_match <= match_next;
      out_done  <= s1_last;
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.match_found = out_match;
  assign result_ch.buffer_done = out_done;

`ifndef SYNTH
  // A held input item keeps its payload until it moves on.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_data) && $stable(s1_last)))
    else $error("input register changed while it was held");

  // An empty input register always takes a new byte.
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> byte_ch.ready)
    else $error("input not ready while the input register is empty");

  // Every byte that moves on shows up as a result that carries its end flag.
  assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> (result_ch.valid && (result_ch.buffer_done == $past(s1_last))))
    else $error("result does not follow the byte that produced it");
`endif

endmodule
